// ----- rtl/lbc_pkg.sv -----
// shared types and constants for the lru block cache tag engine
package lbc_pkg;

	localparam int BN_W   = 24;
	localparam int SLOT_W = 6;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic            func;
		logic [BN_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              fill;
		logic              evict_valid;
		logic [BN_W-1:0]   evict_block;
	} rsp_t;

	// update broadcast from the controller to every cell
	typedef struct packed {
		logic en;
		logic use_victim;
		logic fill;
	} upd_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RED,
		S_UPD
	} state_t;

endpackage

// ----- rtl/lbc_cell.sv -----
// one cache entry: tag, valid bit, age rank and lookup flags
module lbc_cell import lbc_pkg::*; #(
	parameter int IDX_W      = 6,
	parameter int RESET_RANK = 0,
	parameter int LAST_RANK  = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmp_en,
	input  logic [BN_W-1:0]  cmp_tag,
	input  upd_ctl_t         upd,
	input  logic [IDX_W-1:0] sel_rank,
	input  logic [BN_W-1:0]  upd_tag,
	output logic             match_q,
	output logic             victim_q,
	output logic             valid_q,
	output logic [BN_W-1:0]  tag_q,
	output logic [IDX_W-1:0] rank_q
);

	logic selected;

	assign selected = upd.use_victim ? victim_q : match_q;

	// lookup flags, taken when an item is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q  <= 1'b0;
			victim_q <= 1'b0;
		end else if (cmp_en) begin
			match_q  <= valid_q && (tag_q == cmp_tag);
			victim_q <= (rank_q == IDX_W'(LAST_RANK));
		end
	end

	// rank and valid: promote the selected entry, age the more recent ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= IDX_W'(RESET_RANK);
		end else if (upd.en) begin
			if (selected) begin
				rank_q <= '0;
				if (upd.fill) valid_q <= 1'b1;
			end else if (rank_q < sel_rank) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// tag is only meaningful while valid
	always_ff @(posedge clk) begin
		if (upd.en && upd.fill && selected) tag_q <= upd_tag;
	end

endmodule

// ----- rtl/lru_block_cache_tags.sv -----
// top level of the lru block cache tag engine: controller and row of cells
//
// Fully associative tag engine with true LRU ranking over ENTRIES cells. Each
// item goes through these steps in order: the accept edge latches a tag
// compare and a least-recent flag in every cell, the reduce state turns the
// row into the result and the rank to promote from, and the update state
// broadcasts the rank update back to the row; a new item is accepted only
// once the engine is back in idle. The result sits in an output register, so
// a stalled consumer only holds up the reduce step of the following item.
// Slot is the entry index truncated to six bits. After reset all entries are
// invalid and entry i holds rank ENTRIES-1-i; no clearing pass is needed.
module lru_block_cache_tags import lbc_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;

	state_t state_q, state_d;

	req_t             req_q;
	logic             req_acc;
	logic             rsp_load;
	logic             rsp_valid_q;
	rsp_t             rsp_q, rsp_d;

	upd_ctl_t         upd_q, upd_d;
	logic [IDX_W-1:0] sel_rank_q, sel_rank_d;

	logic [ENTRIES-1:0] match_v, victim_v, valid_v;
	logic [BN_W-1:0]    tag_a  [ENTRIES];
	logic [IDX_W-1:0]   rank_a [ENTRIES];

	logic                    any_hit;
	logic [IDX_W-1:0]        hit_idx, victim_idx, hit_rank;
	logic                    evict_valid;
	logic [BN_W-1:0]         evict_tag;
	logic [IDX_W+SLOT_W-1:0] hit_ext, victim_ext;

	assign req_acc   = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_RED) && (!rsp_valid_q || rsp_ready);

	// row of cells
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lbc_cell #(
			.IDX_W     (IDX_W),
			.RESET_RANK(ENTRIES - 1 - g),
			.LAST_RANK (ENTRIES - 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmp_en  (req_acc),
			.cmp_tag (req.block_number),
			.upd     (upd_q),
			.sel_rank(sel_rank_q),
			.upd_tag (req_q.block_number),
			.match_q (match_v[g]),
			.victim_q(victim_v[g]),
			.valid_q (valid_v[g]),
			.tag_q   (tag_a[g]),
			.rank_q  (rank_a[g])
		);
	end

	// and-or reduction of the flags; match and victim are each at most one-hot
	always_comb begin
		any_hit     = |match_v;
		hit_idx     = '0;
		victim_idx  = '0;
		hit_rank    = '0;
		evict_valid = 1'b0;
		evict_tag   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_v[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_a[i];
			end
			if (victim_v[i]) begin
				victim_idx  = victim_idx | IDX_W'(i);
				evict_valid = evict_valid | valid_v[i];
				if (valid_v[i]) evict_tag = evict_tag | tag_a[i];
			end
		end
	end

	assign hit_ext    = {{SLOT_W{1'b0}}, hit_idx};
	assign victim_ext = {{SLOT_W{1'b0}}, victim_idx};

	// result and update command
	always_comb begin
		rsp_d      = '0;
		upd_d      = '0;
		sel_rank_d = hit_rank;
		if (any_hit) begin
			rsp_d.hit  = 1'b1;
			rsp_d.slot = hit_ext[SLOT_W-1:0];
			upd_d.en   = (req_q.func == FUNC_READ);
		end else if (req_q.func == FUNC_READ) begin
			rsp_d.slot        = victim_ext[SLOT_W-1:0];
			rsp_d.fill        = 1'b1;
			rsp_d.evict_valid = evict_valid;
			rsp_d.evict_block = evict_tag;
			upd_d.en          = 1'b1;
			upd_d.use_victim  = 1'b1;
			upd_d.fill        = 1'b1;
			sel_rank_d        = IDX_W'(ENTRIES - 1);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req_acc) state_d = S_RED;
			S_RED:   if (rsp_load) state_d = S_UPD;
			S_UPD:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			upd_q       <= '0;
		end else begin
			if (rsp_load)       rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			upd_q <= rsp_load ? upd_d : '0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) req_q <= req;
		if (rsp_load) begin
			rsp_q      <= rsp_d;
			sel_rank_q <= sel_rank_d;
		end
	end

	// valid tags are unique, so at most one cell matches
	a_match_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED) |-> $onehot0(match_v))
		else $error("several cells match one block");

	// ranks are a permutation, so exactly one cell is least recent
	a_victim_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED) |-> $onehot(victim_v))
		else $error("least recent entry is not unique");

	// a write never touches ranks or tags
	a_write_no_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && req_q.func == FUNC_WRITE) |=> !upd_q.en)
		else $error("write item changed cache state");

	// a fill only follows a miss
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> !(rsp_q.fill && rsp_q.hit))
		else $error("fill reported together with hit");

	// no new item while one is still in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED || state_q == S_UPD) |-> !req_ready)
		else $error("item accepted while another is in flight");

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the lru block cache tag engine
`timescale 1ns / 1ps

module tb;
	import lbc_pkg::*;

	localparam int N_LINES     = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam int POOL_MAX    = 256;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// shadow copy of the tag engine state
	logic [BN_W-1:0] line_tag [N_LINES];
	logic            line_valid [N_LINES];
	int              line_age [N_LINES];

	rsp_t rsp_due [$];

	logic [BN_W-1:0] block_pool [POOL_MAX];
	int pool_used;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;
	int hold_left;
	int quiet_cycles;
	int err_count;
	int n_read_hit, n_read_miss, n_evict, n_write_hit, n_write_miss;

	lru_block_cache_tags #(.ENTRIES(N_LINES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// move entry e to most recent, aging everything that was more recent
	function automatic void make_recent(input int e);
		for (int k = 0; k < N_LINES; k++) begin
			if (k != e && line_age[k] < line_age[e])
				line_age[k]++;
		end
		line_age[e] = 0;
	endfunction

	// expected result of one access, updating the shadow state
	function automatic rsp_t cache_lookup(input req_t a);
		rsp_t r;
		int found;
		int victim;
		r = '0;
		found = -1;
		for (int i = 0; i < N_LINES; i++) begin
			if (found < 0 && line_valid[i] && line_tag[i] == a.block_number)
				found = i;
		end
		if (found >= 0) begin
			r.hit  = 1'b1;
			r.slot = found[SLOT_W-1:0];
			if (a.func == FUNC_READ) begin
				make_recent(found);
				n_read_hit++;
			end else begin
				n_write_hit++;
			end
		end else if (a.func == FUNC_WRITE) begin
			n_write_miss++;
		end else begin
			// read miss: replace the least recent entry
			victim = 0;
			for (int i = 1; i < N_LINES; i++) begin
				if (line_age[i] > line_age[victim])
					victim = i;
			end
			r.slot = victim[SLOT_W-1:0];
			r.fill = 1'b1;
			if (line_valid[victim]) begin
				r.evict_valid = 1'b1;
				r.evict_block = line_tag[victim];
				n_evict++;
			end
			line_tag[victim]   = a.block_number;
			line_valid[victim] = 1'b1;
			make_recent(victim);
			n_read_miss++;
		end
		return r;
	endfunction

	// offer one item, wait for it to be taken, record what should come back
	task automatic send_access(input logic f, input logic [BN_W-1:0] bn);
		req_t a;
		a.func         = f;
		a.block_number = bn;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= a;
		do
			@(posedge clk);
		while (!req_ready);
		rsp_due.push_back(cache_lookup(a));
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// reset state, hits and misses at both ends of the block number range
	task automatic test_directed();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_access(FUNC_READ,  24'h000000);   // zero tag but invalid: miss into invalid entry
		send_access(FUNC_WRITE, 24'hFFFFFF);   // write miss leaves state alone
		send_access(FUNC_READ,  24'hFFFFFF);
		send_access(FUNC_WRITE, 24'hFFFFFF);   // write hit
		send_access(FUNC_READ,  24'h000000);   // read hit on the older entry
		send_access(FUNC_READ,  24'hFFFFFF);
		send_access(FUNC_WRITE, 24'h000000);
		send_access(FUNC_READ,  24'h800000);
		send_access(FUNC_READ,  24'h000001);
		send_access(FUNC_READ,  24'h555555);
		send_access(FUNC_READ,  24'hAAAAAA);
		send_access(FUNC_READ,  24'h000001);   // hit in the middle of the ranking
		send_access(FUNC_WRITE, 24'h123456);
		send_access(FUNC_READ,  24'h000000);
		send_access(FUNC_WRITE, 24'hAAAAAA);
		send_access(FUNC_READ,  24'h7FFFFF);
		send_access(FUNC_READ,  24'h800000);
		drain();
	endtask

	// random accesses over a working set, mostly reads
	task automatic test_random(input int count, input int tx_pct, input int rx_pct,
			input int pool_size);
		logic f;
		logic [BN_W-1:0] bn;
		pool_used = pool_size;
		for (int i = 0; i < pool_size; i++)
			block_pool[i] = BN_W'($urandom);
		block_pool[0] = '0;
		block_pool[1] = '1;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < count; n++) begin
			f = ($urandom_range(0, 3) == 0) ? FUNC_WRITE : FUNC_READ;
			if ($urandom_range(0, 99) < 85)
				bn = block_pool[$urandom_range(0, pool_size - 1)];
			else
				bn = BN_W'($urandom);
			send_access(f, bn);
		end
	endtask

	// long receiver stall while the sender keeps pushing
	task automatic test_backpressure(input int count);
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		hold_request = 300;
		for (int n = 0; n < count; n++)
			send_access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
				block_pool[$urandom_range(0, pool_used - 1)]);
		drain();
	endtask

	// result side ready, with random stalls and requested hold-offs
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual %h", $time, rsp);
			end else begin
				want = rsp_due.pop_front();
				check_field("hit",         32'(want.hit),         32'(rsp.hit));
				check_field("slot",        32'(want.slot),        32'(rsp.slot));
				check_field("fill",        32'(want.fill),        32'(rsp.fill));
				check_field("evict_valid", 32'(want.evict_valid), 32'(rsp.evict_valid));
				check_field("evict_block", 32'(want.evict_block), 32'(rsp.evict_block));
			end
		end
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		rsp_ready <= 1'b0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		hold_request = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		err_count    = 0;
		pool_used    = 1;
		n_read_hit = 0; n_read_miss = 0; n_evict = 0; n_write_hit = 0; n_write_miss = 0;
		// after reset: nothing valid, entry i has rank N_LINES-1-i
		for (int i = 0; i < N_LINES; i++) begin
			line_tag[i]   = '0;
			line_valid[i] = 1'b0;
			line_age[i]   = N_LINES - 1 - i;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(650, 34, 68, 56);
		test_backpressure(50);
		test_random(650, 68, 34, 96);
		test_random(600, 0, 0, 160);
		drain();
		repeat (20) @(posedge clk);

		if (rsp_due.size() != 0) begin
			err_count++;
			$display("%0t: %0d results never arrived", $time, rsp_due.size());
		end
		$display("read hits %0d, read misses %0d (%0d replaced a valid block)",
			n_read_hit, n_read_miss, n_evict);
		$display("write hits %0d, write misses %0d, under random stalls on both sides",
			n_write_hit, n_write_miss);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- lru_block_cache_tags.f -----
rtl/lbc_pkg.sv
rtl/lbc_cell.sv
rtl/lru_block_cache_tags.sv
bench/tb.sv
